// File: sv/kls_pkg.sv
// Shared types and constants for the keyed list store.
`default_nettype none
package kls_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned ENTRY_W = 5;

  localparam logic [KEY_W-1:0] INT_MAX = 32'h7FFF_FFFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT    = 3'd0,
    FUNC_REMOVE    = 3'd1,
    FUNC_POP_FRONT = 3'd2,
    FUNC_POP_BACK  = 3'd3,
    FUNC_QUERY     = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  // Broadcast to every cell for the beat being taken
  typedef struct packed {
    logic              en;
    func_e             func;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  count;
    logic              ins_ok;
  } cell_ctl_t;

  // Rippled from front to back: first selected entry and its key
  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] value;
  } cell_chain_t;

endpackage
`default_nettype wire

// File: sv/kls_cell.sv
// One slot of the key chain: holds a key, matches, and shifts with its neighbours.
`default_nettype none
module kls_cell
  import kls_pkg::*;
(
  input  wire logic              clk_i,
  input  wire cell_ctl_t         ctl_i,
  input  wire logic [IDX_W-1:0]  idx_i,
  input  wire logic [KEY_W-1:0]  left_key_i,
  input  wire logic [KEY_W-1:0]  right_key_i,
  input  wire cell_chain_t       chain_i,
  output cell_chain_t            chain_o,
  output logic [KEY_W-1:0]       key_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic             occ;
  logic             sel;

  assign occ = CNT_W'(idx_i) < ctl_i.count;

  always_comb begin
    case (ctl_i.func) inside
      FUNC_REMOVE, FUNC_QUERY: sel = occ && (key_q == ctl_i.key) && !chain_i.found;
      FUNC_POP_FRONT:          sel = occ && (idx_i == '0);
      FUNC_POP_BACK:           sel = occ && ((CNT_W'(idx_i) + CNT_W'(1)) == ctl_i.count);
      default:                 sel = 1'b0;
    endcase
  end

  assign chain_o.found = chain_i.found | sel;
  assign chain_o.value = sel ? key_q : chain_i.value;

  // insert: everything moves back; remove and pop front: slots from the hit onward close up
  always_comb begin
    key_d = key_q;
    if (ctl_i.en) begin
      case (ctl_i.func) inside
        FUNC_INSERT: begin
          if (ctl_i.ins_ok) key_d = left_key_i;
        end
        FUNC_REMOVE, FUNC_POP_FRONT: begin
          if (chain_o.found) key_d = right_key_i;
        end
        default: key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule
`default_nettype wire

// File: sv/keyed_list_store.sv
// Top level of the keyed list store: a chain of key cells plus count and result register.
//
// Ordered store of up to DEPTH 32-bit keys, front at cell 0.
// Input channel (in_valid_i/in_ready_o) carries func_i and key_i: insert at front,
// remove first matching key, pop front, pop back, or membership query.
// Output channel (out_valid_o/out_ready_i) returns one beat per input beat:
// status_o, value_o (removed key or 7FFF_FFFF) and entry_count_o.
// The result is registered and shows in the cycle after the input beat.
// Throughput: one beat per cycle unless back-pressured. Every cell compares
// its key in parallel and a found flag ripples down the chain, so the whole
// operation resolves in a single pass of the cell row and the shift lands at
// the same clock edge. A new input beat is taken while the result register is
// empty or being drained in that cycle; a stalled receiver holds the result
// and back-pressures the input side after one beat.
// Reset empties the store (count to zero) and drops any pending result; key
// cells are not reset since a slot is only read after it has been written.
`default_nettype none
module keyed_list_store
  import kls_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [FUNC_W-1:0]   func_i,
  input  wire logic signed [KEY_W-1:0] key_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [KEY_W-1:0]  value_o,
  output logic [ENTRY_W-1:0]       entry_count_o
);

  logic               in_fire;
  func_e              func;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic [KEY_W-1:0]   value_q, value_d;
  logic [CNT_W-1:0]   res_count_q;
  cell_ctl_t          ctl;
  cell_chain_t        chain [DEPTH+1];
  logic [KEY_W-1:0]   cell_key [DEPTH];
  logic               found;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign func       = func_e'(func_i);

  assign ctl.en     = in_fire;
  assign ctl.func   = func;
  assign ctl.key    = key_i;
  assign ctl.count  = count_q;
  assign ctl.ins_ok = count_q < CNT_W'(DEPTH);

  assign chain[0].found = 1'b0;
  assign chain[0].value = INT_MAX;

  // Cell row: each cell sees its neighbours' keys; front takes the new key,
  // back refills from itself (that slot falls out of the count anyway)
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] left_key, right_key;
    if (i == 0) begin : g_front
      assign left_key = key_i;
    end else begin : g_mid_l
      assign left_key = cell_key[i-1];
    end
    if (i == DEPTH - 1) begin : g_back
      assign right_key = cell_key[i];
    end else begin : g_mid_r
      assign right_key = cell_key[i+1];
    end

    kls_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .idx_i       (IDX_W'(i)),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .chain_i     (chain[i]),
      .chain_o     (chain[i+1]),
      .key_o       (cell_key[i])
    );
  end

  assign found = chain[DEPTH].found;

  // Result and count for the beat being taken
  always_comb begin
    count_d  = count_q;
    status_d = STAT_NONE;
    value_d  = INT_MAX;
    unique case (func) inside
      FUNC_INSERT: begin
        if (ctl.ins_ok) begin
          status_d = STAT_OK;
          count_d  = count_q + CNT_W'(1);
        end else begin
          status_d = STAT_FULL;
        end
      end
      FUNC_REMOVE, FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (found) begin
          status_d = STAT_OK;
          value_d  = chain[DEPTH].value;
          count_d  = count_q - CNT_W'(1);
        end
      end
      FUNC_QUERY: begin
        if (found) status_d = STAT_OK;
      end
      default: status_d = STAT_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire)          out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) count_q <= count_d;
    end
  end

  // Result payload, loaded with each taken beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q    <= status_d;
      value_q     <= value_d;
      res_count_q <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign value_o       = value_q;
  assign entry_count_o = ENTRY_W'(res_count_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && func == FUNC_INSERT && count_q == CNT_W'(DEPTH)) |=>
      (status_q == STAT_FULL && $stable(count_q)))
    else $error("insert into full store not dropped");

  a_query_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && func == FUNC_QUERY) |=> ($stable(count_q) && value_q == INT_MAX))
    else $error("membership query altered store");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (func == FUNC_POP_FRONT || func == FUNC_POP_BACK) && count_q != '0)
      |=> (status_q == STAT_OK && count_q == $past(count_q) - CNT_W'(1)))
    else $error("pop on non-empty store failed");
`endif

endmodule
`default_nettype wire
